// ----- src/spc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_pkg
// Types, codes and the CRC-16/CCITT-FALSE byte step for the packet checker.
// ----------------------------------------------------------------------------
package spc_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [15:0] ID_WIND         = 16'hF179;
  localparam logic [15:0] ID_AIR          = 16'hA41B;
  localparam logic [15:0] ID_WATER        = 16'hC946;
  localparam logic [15:0] ID_LIGHTNING_UV = 16'hD255;

  // counts are compared at this width whatever the packet limit
  localparam int CNT_EXT_W = 6;

  localparam logic [CNT_EXT_W-1:0] LEN_WIND         = 6'd12;
  localparam logic [CNT_EXT_W-1:0] LEN_AIR          = 6'd12;
  localparam logic [CNT_EXT_W-1:0] LEN_WATER        = 6'd10;
  localparam logic [CNT_EXT_W-1:0] LEN_LIGHTNING_UV = 6'd14;
  localparam logic [CNT_EXT_W-1:0] LEN_MIN          = 6'd4;

  localparam int WORD_DEPTH = 7;
  localparam int WORD_IDX_W = 3;

  localparam logic [2:0] STATUS_ACCEPTED  = 3'd0;
  localparam logic [2:0] STATUS_CRC_ERROR = 3'd1;
  localparam logic [2:0] STATUS_UNKNOWN   = 3'd2;
  localparam logic [2:0] STATUS_TOO_LONG  = 3'd3;
  localparam logic [2:0] STATUS_TOO_SHORT = 3'd4;

  localparam logic [2:0] KIND_WIND         = 3'd0;
  localparam logic [2:0] KIND_AIR          = 3'd1;
  localparam logic [2:0] KIND_WATER        = 3'd2;
  localparam logic [2:0] KIND_LIGHTNING_UV = 3'd3;
  localparam logic [2:0] KIND_NONE         = 3'd4;

  typedef logic [15:0] word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] kind;
    logic       length_mismatch;
    logic [4:0] byte_count;
    word_t      packet_id;
    word_t      received_crc;
    word_t      word_one;
    word_t      word_two;
    word_t      word_three;
    word_t      word_four;
    word_t      word_five;
    word_t      word_six;
  } result_t;

  // one byte of crc-16, poly 0x1021, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [7:0] x;
    x = c[15:8] ^ b;
    x = x ^ (x >> 4);
    return {c[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000} ^ {8'h00, x};
  endfunction

endpackage

// ----- src/spc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_if
// Valid/ready channels for packet bytes and check results.
// ----------------------------------------------------------------------------
interface spc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface spc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  kind;
  logic        length_mismatch;
  logic [4:0]  byte_count;
  logic [15:0] packet_id;
  logic [15:0] received_crc;
  logic [15:0] word_one;
  logic [15:0] word_two;
  logic [15:0] word_three;
  logic [15:0] word_four;
  logic [15:0] word_five;
  logic [15:0] word_six;

  modport source (
    output valid, input ready,
    output status, output kind, output length_mismatch, output byte_count,
    output packet_id, output received_crc,
    output word_one, output word_two, output word_three,
    output word_four, output word_five, output word_six
  );
  modport sink (
    input valid, output ready,
    input status, input kind, input length_mismatch, input byte_count,
    input packet_id, input received_crc,
    input word_one, input word_two, input word_three,
    input word_four, input word_five, input word_six
  );
endinterface

// ----- src/sensor_packet_checker_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_packet_checker_core
// CRC-16/CCITT-FALSE frame check and id classification of sensor packets.
// ----------------------------------------------------------------------------
// the last byte passes the input register, then the result register, which raises valid
// throughput: one byte per cycle via the work-stage crc step; a last byte waits on a busy result slot
// the result register lets the next packet stream in while a result waits
// reset: synchronous, clears valid flags, crc, count, delay line and word store
module sensor_packet_checker_core #(
  parameter int MAX_BYTES = 16
) (
  input logic        clk,
  input logic        rst,
  spc_in_if.sink     pkt_in,
  spc_out_if.source  res_out
);

  localparam int CountW = $clog2(MAX_BYTES + 2);
  localparam logic [spc_pkg::CNT_EXT_W-1:0] MaxExt = spc_pkg::CNT_EXT_W'(MAX_BYTES);
  localparam logic [spc_pkg::CNT_EXT_W-1:0] StoreLimit =
    spc_pkg::CNT_EXT_W'(2 * spc_pkg::WORD_DEPTH);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // packet state
  logic [15:0]         crc;
  logic [CountW-1:0]   count;
  logic [7:0]          lag [2];
  spc_pkg::word_t      word_store [spc_pkg::WORD_DEPTH];

  // result register
  logic             res_valid;
  spc_pkg::result_t res;

  logic                              step;
  logic [spc_pkg::CNT_EXT_W-1:0]     cnt_ext;
  logic [spc_pkg::CNT_EXT_W-1:0]     n;
  logic [15:0]                       crc_upd;
  logic                              store_en;
  logic                              word_wr;
  logic [spc_pkg::WORD_IDX_W-1:0]    widx;
  spc_pkg::word_t                    words_upd [spc_pkg::WORD_DEPTH];
  spc_pkg::result_t                  res_next;

  // the work stage holds a last byte only while the result slot is busy
  assign step         = in_valid && (!in_last || !res_valid || res_out.ready);
  assign pkt_in.ready = !in_valid || step;

  assign cnt_ext  = spc_pkg::CNT_EXT_W'(count);
  assign crc_upd  = (cnt_ext >= spc_pkg::CNT_EXT_W'(2)) ? spc_pkg::crc_byte(crc, lag[0]) : crc;
  assign store_en = cnt_ext <= MaxExt;
  assign word_wr  = store_en && (cnt_ext < StoreLimit);
  assign widx     = cnt_ext[spc_pkg::WORD_IDX_W:1];
  assign n        = store_en ? cnt_ext + spc_pkg::CNT_EXT_W'(1) : cnt_ext;

  always_comb begin
    words_upd = word_store;
    if (word_wr) begin
      if (cnt_ext[0]) begin
        words_upd[widx][15:8] = in_byte;
      end else begin
        words_upd[widx][7:0] = in_byte;
      end
    end
  end

  always_comb begin
    spc_pkg::word_t                rcrc;
    spc_pkg::word_t                w [6];
    logic [spc_pkg::CNT_EXT_W-1:0] expected;
    logic [2:0]                    kind;
    // trailer is the byte in the delay line plus the byte just taken
    rcrc     = {in_byte, lag[1]};
    expected = '0;
    for (int k = 1; k <= 6; k++) begin
      w[k-1] = (spc_pkg::CNT_EXT_W'(2 * k + 3) < n) ? words_upd[k] : '0;
    end
    unique case (words_upd[0])
      spc_pkg::ID_WIND: begin
        kind = spc_pkg::KIND_WIND;
        expected = spc_pkg::LEN_WIND;
      end
      spc_pkg::ID_AIR: begin
        kind = spc_pkg::KIND_AIR;
        expected = spc_pkg::LEN_AIR;
      end
      spc_pkg::ID_WATER: begin
        kind = spc_pkg::KIND_WATER;
        expected = spc_pkg::LEN_WATER;
      end
      spc_pkg::ID_LIGHTNING_UV: begin
        kind = spc_pkg::KIND_LIGHTNING_UV;
        expected = spc_pkg::LEN_LIGHTNING_UV;
      end
      default: kind = spc_pkg::KIND_NONE;
    endcase

    res_next.byte_count      = n[4:0];
    res_next.packet_id       = words_upd[0];
    res_next.kind            = spc_pkg::KIND_NONE;
    res_next.length_mismatch = 1'b0;
    res_next.received_crc    = '0;
    res_next.word_one        = '0;
    res_next.word_two        = '0;
    res_next.word_three      = '0;
    res_next.word_four       = '0;
    res_next.word_five       = '0;
    res_next.word_six        = '0;
    priority if (n > MaxExt) begin
      res_next.status = spc_pkg::STATUS_TOO_LONG;
    end else if (n < spc_pkg::LEN_MIN) begin
      res_next.status = spc_pkg::STATUS_TOO_SHORT;
    end else begin
      res_next.received_crc = rcrc;
      res_next.word_one     = w[0];
      res_next.word_two     = w[1];
      res_next.word_three   = w[2];
      res_next.word_four    = w[3];
      res_next.word_five    = w[4];
      res_next.word_six     = w[5];
      res_next.kind         = kind;
      if (kind == spc_pkg::KIND_NONE) begin
        res_next.status = spc_pkg::STATUS_UNKNOWN;
      end else begin
        res_next.length_mismatch = n != expected;
        res_next.status = (crc_upd == rcrc) ? spc_pkg::STATUS_ACCEPTED
                                            : spc_pkg::STATUS_CRC_ERROR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      res_valid <= 1'b0;
      crc       <= spc_pkg::CRC_INIT;
      count     <= '0;
      lag[0]    <= '0;
      lag[1]    <= '0;
      for (int i = 0; i < spc_pkg::WORD_DEPTH; i++) begin
        word_store[i] <= '0;
      end
    end else begin
      if (pkt_in.ready) begin
        in_valid <= pkt_in.valid;
      end
      if (step && in_last) begin
        crc    <= spc_pkg::CRC_INIT;
        count  <= '0;
        lag[0] <= '0;
        lag[1] <= '0;
        for (int i = 0; i < spc_pkg::WORD_DEPTH; i++) begin
          word_store[i] <= '0;
        end
      end else if (step) begin
        crc        <= crc_upd;
        count      <= CountW'(n);
        lag[0]     <= lag[1];
        lag[1]     <= in_byte;
        word_store <= words_upd;
      end
      if (step && in_last) begin
        res_valid <= 1'b1;
      end else if (res_out.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_in.valid && pkt_in.ready) begin
      in_byte <= pkt_in.data_byte;
      in_last <= pkt_in.last_byte;
    end
    if (step && in_last) begin
      res <= res_next;
    end
  end

  assign res_out.valid           = res_valid;
  assign res_out.status          = res.status;
  assign res_out.kind            = res.kind;
  assign res_out.length_mismatch = res.length_mismatch;
  assign res_out.byte_count      = res.byte_count;
  assign res_out.packet_id       = res.packet_id;
  assign res_out.received_crc    = res.received_crc;
  assign res_out.word_one        = res.word_one;
  assign res_out.word_two        = res.word_two;
  assign res_out.word_three      = res.word_three;
  assign res_out.word_four       = res.word_four;
  assign res_out.word_five       = res.word_five;
  assign res_out.word_six        = res.word_six;

endmodule

// ----- src/spc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_checker
// Port-level checks on the packet checker results, bound to the top level.
// ----------------------------------------------------------------------------
module spc_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [2:0]  status,
  input logic [2:0]  kind,
  input logic        length_mismatch,
  input logic [4:0]  byte_count,
  input logic [15:0] received_crc,
  input logic [15:0] word_one
);

  // a stalled result beat stays up
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result beat dropped while stalled");

  // an accepted or crc-failed status always carries a known kind
  a_kind: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == spc_pkg::STATUS_ACCEPTED ||
                  status == spc_pkg::STATUS_CRC_ERROR) |-> kind != spc_pkg::KIND_NONE)
    else $error("checked packet without a kind");

  // rejected on length: no kind, no trailer, no first word, no mismatch flag
  a_len_reject: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == spc_pkg::STATUS_TOO_LONG ||
                  status == spc_pkg::STATUS_TOO_SHORT) |->
      kind == spc_pkg::KIND_NONE && received_crc == 16'h0000 &&
      word_one == 16'h0000 && !length_mismatch)
    else $error("length reject carries payload");

  a_short: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == spc_pkg::STATUS_TOO_SHORT |-> byte_count < 5'd4)
    else $error("short status on a long enough packet");

  a_wind_len: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == spc_pkg::KIND_WIND && !length_mismatch |-> byte_count == 5'd12)
    else $error("wind packet length flag wrong");

endmodule

bind sensor_packet_checker_core spc_checker u_spc_checker (
  .clk             (clk),
  .rst             (rst),
  .res_valid       (res_out.valid),
  .res_ready       (res_out.ready),
  .status          (res_out.status),
  .kind            (res_out.kind),
  .length_mismatch (res_out.length_mismatch),
  .byte_count      (res_out.byte_count),
  .received_crc    (res_out.received_crc),
  .word_one        (res_out.word_one)
);

// ----- verif/sensor_packet_checker_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_packet_checker_core_tb
// Streams sensor packets into the checker and compares every packet verdict
// with a fixed table result or an in-bench frame checker. A short table covers
// the length extremes, unknown ids and saturation; random packets follow,
// mostly well formed with a valid crc trailer, mixed with corrupted and noise
// packets. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module sensor_packet_checker_core_tb;

  localparam int PKT_MAX = 16;
  localparam int RAND_BYTES = 750;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS = 10;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef struct {
    logic [7:0]       data;
    logic             last;
    bit               typed;
    spc_pkg::result_t exp;
  } stim_row_t;

  logic clk;
  logic rst;

  spc_in_if  pkt_in ();
  spc_out_if res_out ();

  sensor_packet_checker_core #(
    .MAX_BYTES (PKT_MAX)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .pkt_in  (pkt_in),
    .res_out (res_out)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // frame checker state
  logic [15:0] fc_crc;
  int          fc_count;
  logic [7:0]  fc_lag [2];
  logic [15:0] fc_words [spc_pkg::WORD_DEPTH];

  spc_pkg::result_t pending_results [$];
  int               error_count = 0;
  int               burst_left = 0;
  int               idle_cycles = 0;

  function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    int          i;
    v = c ^ {b, 8'h00};
    for (i = 0; i < 8; i++) begin
      v = v[15] ? ((v << 1) ^ CRC_POLY) : (v << 1);
    end
    return v;
  endfunction

  function automatic spc_pkg::result_t outcome(input logic [2:0] st, input logic [2:0] kd,
                                               input logic [4:0] n, input logic [15:0] id,
                                               input logic [15:0] rcrc);
    spc_pkg::result_t r;
    r = '0;
    r.status = st;
    r.kind = kd;
    r.byte_count = n;
    r.packet_id = id;
    r.received_crc = rcrc;
    return r;
  endfunction

  function automatic stim_row_t row(input logic [7:0] d, input logic l, input bit typed,
                                    input spc_pkg::result_t exp);
    stim_row_t s;
    s.data = d;
    s.last = l;
    s.typed = typed;
    s.exp = exp;
    return s;
  endfunction

  function automatic string fmt(input spc_pkg::result_t r);
    return $sformatf("st=%0d kd=%0d lm=%0d n=%0d id=%h crc=%h w=%h %h %h %h %h %h",
                     r.status, r.kind, r.length_mismatch, r.byte_count, r.packet_id,
                     r.received_crc, r.word_one, r.word_two, r.word_three, r.word_four,
                     r.word_five, r.word_six);
  endfunction

  task automatic clear_frame();
    int i;
    fc_crc = spc_pkg::CRC_INIT;
    fc_count = 0;
    fc_lag[0] = 8'h00;
    fc_lag[1] = 8'h00;
    for (i = 0; i < spc_pkg::WORD_DEPTH; i++) fc_words[i] = 16'h0000;
  endtask

  // advance the frame checker by one byte; a verdict comes out on the last byte
  task automatic check_packet_byte(input logic [7:0] b, input logic l, output bit done,
                                   output spc_pkg::result_t r);
    int          c;
    int          n;
    int          k;
    int          want_len;
    logic [15:0] words [6];
    c = fc_count;
    done = 1'b0;
    r = '0;
    if (c >= 2) fc_crc = crc_update(fc_crc, fc_lag[0]);
    fc_lag[0] = fc_lag[1];
    fc_lag[1] = b;
    // bytes past the saturation point only move through the delay line and the crc
    if (c <= PKT_MAX) begin
      if (c < 2 * spc_pkg::WORD_DEPTH) begin
        if (c % 2 == 1) fc_words[c / 2][15:8] = b;
        else fc_words[c / 2][7:0] = b;
      end
      fc_count = c + 1;
    end
    if (l) begin
      n = fc_count;
      done = 1'b1;
      for (k = 0; k < 6; k++) words[k] = 16'h0000;
      r.kind = spc_pkg::KIND_NONE;
      if (n > PKT_MAX) begin
        r.status = spc_pkg::STATUS_TOO_LONG;
      end else if (n < int'(spc_pkg::LEN_MIN)) begin
        r.status = spc_pkg::STATUS_TOO_SHORT;
      end else begin
        r.received_crc = {fc_lag[1], fc_lag[0]};
        // a word counts only if it ends before the trailer
        for (k = 1; k <= 6; k++) begin
          if (2 * k + 3 < n) words[k - 1] = fc_words[k];
        end
        want_len = 0;
        case (fc_words[0])
          spc_pkg::ID_WIND: begin
            r.kind = spc_pkg::KIND_WIND;
            want_len = int'(spc_pkg::LEN_WIND);
          end
          spc_pkg::ID_AIR: begin
            r.kind = spc_pkg::KIND_AIR;
            want_len = int'(spc_pkg::LEN_AIR);
          end
          spc_pkg::ID_WATER: begin
            r.kind = spc_pkg::KIND_WATER;
            want_len = int'(spc_pkg::LEN_WATER);
          end
          spc_pkg::ID_LIGHTNING_UV: begin
            r.kind = spc_pkg::KIND_LIGHTNING_UV;
            want_len = int'(spc_pkg::LEN_LIGHTNING_UV);
          end
          default: r.kind = spc_pkg::KIND_NONE;
        endcase
        if (r.kind == spc_pkg::KIND_NONE) begin
          r.status = spc_pkg::STATUS_UNKNOWN;
        end else begin
          r.length_mismatch = (n != want_len);
          r.status = (fc_crc == r.received_crc) ? spc_pkg::STATUS_ACCEPTED
                                                : spc_pkg::STATUS_CRC_ERROR;
        end
      end
      r.byte_count = n[4:0];
      r.packet_id = fc_words[0];
      r.word_one = words[0];
      r.word_two = words[1];
      r.word_three = words[2];
      r.word_four = words[3];
      r.word_five = words[4];
      r.word_six = words[5];
      clear_frame();
    end
  endtask

  // hand one byte over, then pace the sender in bursts with random gaps
  task automatic deliver(input logic [7:0] b, input logic l, input bit typed,
                         input spc_pkg::result_t fixed);
    bit               done;
    spc_pkg::result_t r;
    pkt_in.valid <= 1'b1;
    pkt_in.data_byte <= b;
    pkt_in.last_byte <= l;
    do @(posedge clk); while (!pkt_in.ready);
    check_packet_byte(b, l, done, r);
    if (done) pending_results.push_back(typed ? fixed : r);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(40, 80);
      end else begin
        burst_left = $urandom_range(1, 24);
        pkt_in.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  // waits on the clock before looking at the queue so the idle drive settles first
  task automatic wait_results_drained();
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic random_packet(output int sent);
    logic [7:0]  pkt [$];
    logic [15:0] id;
    logic [15:0] crc;
    int          len;
    int          sel;
    int          i;
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      case ($urandom_range(0, 3))
        0: begin
          id = spc_pkg::ID_WIND;
          len = int'(spc_pkg::LEN_WIND);
        end
        1: begin
          id = spc_pkg::ID_AIR;
          len = int'(spc_pkg::LEN_AIR);
        end
        2: begin
          id = spc_pkg::ID_WATER;
          len = int'(spc_pkg::LEN_WATER);
        end
        default: begin
          id = spc_pkg::ID_LIGHTNING_UV;
          len = int'(spc_pkg::LEN_LIGHTNING_UV);
        end
      endcase
      if ($urandom_range(0, 4) == 0) len = $urandom_range(int'(spc_pkg::LEN_MIN), PKT_MAX);
      pkt.push_back(id[7:0]);
      pkt.push_back(id[15:8]);
      while (pkt.size() < len - 2) pkt.push_back(8'($urandom));
      crc = spc_pkg::CRC_INIT;
      for (i = 0; i < pkt.size(); i++) crc = crc_update(crc, pkt[i]);
      if ($urandom_range(0, 9) == 0) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      pkt.push_back(crc[7:0]);
      pkt.push_back(crc[15:8]);
    end else begin
      len = $urandom_range(1, PKT_MAX + 6);
      repeat (len) pkt.push_back(8'($urandom));
      // noise that still carries a known id
      if (sel == 8 && len >= 2) begin
        case ($urandom_range(0, 3))
          0: id = spc_pkg::ID_WIND;
          1: id = spc_pkg::ID_AIR;
          2: id = spc_pkg::ID_WATER;
          default: id = spc_pkg::ID_LIGHTNING_UV;
        endcase
        pkt[0] = id[7:0];
        pkt[1] = id[15:8];
      end
    end
    for (i = 0; i < pkt.size(); i++) deliver(pkt[i], i == pkt.size() - 1, 1'b0, '0);
    sent = pkt.size();
  endtask

  // receiver stalls follow a mode and pattern drawn anew each time the phase counter wraps
  logic        rx_ready = 1'b0;
  int          rx_mode = 0;
  logic [15:0] rx_pattern = 16'hFFFF;
  logic [5:0]  rx_phase = 6'd0;

  assign res_out.ready = rx_ready;

  always @(posedge clk) begin
    rx_phase <= rx_phase + 6'd1;
    if (rx_phase == 6'd0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_pattern <= 16'($urandom);
    end
    case (rx_mode)
      0: rx_ready <= 1'b1;
      1: rx_ready <= rx_pattern[rx_phase[3:0]];
      default: rx_ready <= (rx_phase[2:0] == 3'd0);
    endcase
  end

  always @(posedge clk) begin
    spc_pkg::result_t act;
    spc_pkg::result_t exp;
    if (!rst && res_out.valid && res_out.ready) begin
      act.status = res_out.status;
      act.kind = res_out.kind;
      act.length_mismatch = res_out.length_mismatch;
      act.byte_count = res_out.byte_count;
      act.packet_id = res_out.packet_id;
      act.received_crc = res_out.received_crc;
      act.word_one = res_out.word_one;
      act.word_two = res_out.word_two;
      act.word_three = res_out.word_three;
      act.word_four = res_out.word_four;
      act.word_five = res_out.word_five;
      act.word_six = res_out.word_six;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) $display("unexpected result: %s", fmt(act));
      end else begin
        exp = pending_results.pop_front();
        if (act.status !== exp.status || act.kind !== exp.kind ||
            act.length_mismatch !== exp.length_mismatch ||
            act.byte_count !== exp.byte_count || act.packet_id !== exp.packet_id ||
            act.received_crc !== exp.received_crc || act.word_one !== exp.word_one ||
            act.word_two !== exp.word_two || act.word_three !== exp.word_three ||
            act.word_four !== exp.word_four || act.word_five !== exp.word_five ||
            act.word_six !== exp.word_six) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("result mismatch at %0t", $realtime);
            $display("  expected %s", fmt(exp));
            $display("  actual   %s", fmt(act));
          end
        end
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (pkt_in.valid && pkt_in.ready) || (res_out.valid && res_out.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("sensor_packet_checker_core regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stim_row_t dir_tab [$];
    int        i;
    int        sent;
    int        rand_total;
    bit        paused;
    rst <= 1'b1;
    pkt_in.valid <= 1'b0;
    pkt_in.data_byte <= 8'h00;
    pkt_in.last_byte <= 1'b0;
    clear_frame();

    // single byte, too short
    dir_tab.push_back(row(8'hFF, 1'b1, 1'b1,
                          outcome(spc_pkg::STATUS_TOO_SHORT, spc_pkg::KIND_NONE, 5'd1,
                                  16'h00FF, 16'h0000)));
    // two bytes, id complete but still too short
    dir_tab.push_back(row(8'h34, 1'b0, 1'b0, '0));
    dir_tab.push_back(row(8'h12, 1'b1, 1'b1,
                          outcome(spc_pkg::STATUS_TOO_SHORT, spc_pkg::KIND_NONE, 5'd2,
                                  16'h1234, 16'h0000)));
    // minimum length with an unknown id
    dir_tab.push_back(row(8'h00, 1'b0, 1'b0, '0));
    dir_tab.push_back(row(8'h00, 1'b0, 1'b0, '0));
    dir_tab.push_back(row(8'hCD, 1'b0, 1'b0, '0));
    dir_tab.push_back(row(8'hAB, 1'b1, 1'b1,
                          outcome(spc_pkg::STATUS_UNKNOWN, spc_pkg::KIND_NONE, 5'd4,
                                  16'h0000, 16'hABCD)));
    // known kind at minimum length, no payload words
    dir_tab.push_back(row(spc_pkg::ID_AIR[7:0], 1'b0, 1'b0, '0));
    dir_tab.push_back(row(spc_pkg::ID_AIR[15:8], 1'b0, 1'b0, '0));
    dir_tab.push_back(row(8'h5A, 1'b0, 1'b0, '0));
    dir_tab.push_back(row(8'hA5, 1'b1, 1'b0, '0));
    // too long, count saturates one past the limit
    dir_tab.push_back(row(spc_pkg::ID_WIND[7:0], 1'b0, 1'b0, '0));
    dir_tab.push_back(row(spc_pkg::ID_WIND[15:8], 1'b0, 1'b0, '0));
    for (i = 0; i < PKT_MAX; i++) begin
      if (i == PKT_MAX - 1) begin
        dir_tab.push_back(row(8'h00, 1'b1, 1'b1,
                              outcome(spc_pkg::STATUS_TOO_LONG, spc_pkg::KIND_NONE,
                                      5'(PKT_MAX + 1), spc_pkg::ID_WIND, 16'h0000)));
      end else begin
        dir_tab.push_back(row((i % 2 == 0) ? 8'hFF : 8'h00, 1'b0, 1'b0, '0));
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < dir_tab.size(); i++) begin
      deliver(dir_tab[i].data, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].exp);
    end

    pkt_in.valid <= 1'b0;
    wait_results_drained();

    rand_total = 0;
    paused = 1'b0;
    while (rand_total < RAND_BYTES) begin
      random_packet(sent);
      rand_total += sent;
      if (!paused && rand_total >= RAND_BYTES / 2) begin
        paused = 1'b1;
        pkt_in.valid <= 1'b0;
        wait_results_drained();
      end
    end

    pkt_in.valid <= 1'b0;
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("sensor_packet_checker_core regression: pass");
    end else begin
      $display("sensor_packet_checker_core regression: fail");
    end
    $finish;
  end

endmodule
